>>> hdl/vnce_pkg.sv
// Package for the voxel erosion block: command codes, register indexes,
// sequencer state codes and default sizes. No dependencies.
`timescale 1ns / 1ps
package vnce_pkg;
  localparam int VOLUME_EDGE_DEF = 32;

  localparam logic [1:0] CMD_LOAD_SOLID  = 2'd0;
  localparam logic [1:0] CMD_LOAD_ANCHOR = 2'd1;
  localparam logic [1:0] CMD_RUN         = 2'd2;
  localparam logic [1:0] CMD_READ        = 2'd3;

  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_MAX_PASSES = 1'b1;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_IDX1   = 4'd2;
  localparam logic [3:0] S_IDX2   = 4'd3;
  localparam logic [3:0] S_RESP   = 4'd4;
  localparam logic [3:0] S_PASS   = 4'd5;
  localparam logic [3:0] S_V_RD   = 4'd6;
  localparam logic [3:0] S_V_CHK  = 4'd7;
  localparam logic [3:0] S_NB     = 4'd8;
  localparam logic [3:0] S_DEC    = 4'd9;
  localparam logic [3:0] S_SW_RD  = 4'd10;
  localparam logic [3:0] S_SW_WR  = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;
endpackage

>>> hdl/vnce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vnce_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/voxel_neighbor_count_erode.sv
// Voxel erosion block top level: command decode, pass sequencer, neighbor count.
// Depends on vnce_pkg and vnce_ram.
`timescale 1ns / 1ps
//
// Usage:
//   An item is taken when start is high and busy is low. Each item gives one
//   result, shown for exactly one cycle with done high; the receiver cannot stall.
//   Results carry read_bit plus removed_count / passes_done of the last run.
//   Configuration (index 0 remove_threshold, 1 max_passes) is written over
//   cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is always high.
// Sequence:
//   Load and read: the item passes S_IDX1 and S_IDX2, then done is shown in
//   S_RESP; the next item is accepted only once the block is back in S_IDLE.
//   Run: each pass scans every voxel with one shared solid/anchor read port pair:
//   S_V_RD and S_V_CHK per voxel, S_NB over the six neighbors of a solid one, then
//   S_DEC; then a removal sweep of S_SW_RD and S_SW_WR per voxel when anything was
//   marked, else the run finishes.
// Reset:
//   After rst, busy stays high while the solid and anchor memories are cleared
//   one entry per cycle.
//
module voxel_neighbor_count_erode
  import vnce_pkg::*;
#(
  parameter int VOLUME_EDGE = VOLUME_EDGE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic signed [6:0] pos_x,
  input  logic signed [6:0] pos_y,
  input  logic signed [6:0] pos_z,
  input  logic              bit_value,
  output logic              done,
  output logic              read_bit,
  output logic [15:0]       removed_count,
  output logic [7:0]        passes_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  localparam int E   = VOLUME_EDGE;
  localparam int P   = VOLUME_EDGE + 2;
  localparam int E2  = E * E;
  localparam int P2  = P * P;
  localparam int SC  = E * E * E;
  localparam int AC  = P * P * P;
  localparam int SW  = $clog2(SC);
  localparam int AW  = $clog2(AC);
  localparam int CW  = $clog2(E);
  localparam int MW  = SW + 1;

  logic [3:0]        state;
  logic [1:0]        cmd_r;
  logic signed [6:0] px, py, pz;
  logic              bit_r;
  logic [SW-1:0]     ts;
  logic [AW-1:0]     ta;
  logic              rd_ok;
  logic [AW-1:0]     clr;
  logic [SW-1:0]     sidx;
  logic [AW-1:0]     aidx;
  logic [CW-1:0]     vx, vy, vz;
  logic [2:0]        nb, cnt;
  logic              cur_solid, nb_ok;
  logic [MW-1:0]     marked;
  logic [15:0]       removed;
  logic [7:0]        passes;
  logic [15:0]       last_removed;
  logic [7:0]        last_passes;
  logic [2:0]        thr;
  logic [7:0]        maxp;

  // memory ports
  logic          s_we, s_wd, s_rd, a_we, a_wd, a_rd, m_we, m_wd, m_rd;
  logic [SW-1:0] s_wa, s_ra, m_wa, m_ra;
  logic [AW-1:0] a_wa, a_ra;

  vnce_ram #(.WIDTH(1), .DEPTH(SC)) u_solid (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  vnce_ram #(.WIDTH(1), .DEPTH(AC)) u_anchor (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  vnce_ram #(.WIDTH(1), .DEPTH(SC)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  logic in_s, in_a;
  logic [SW-1:0] cs_idx;
  logic [AW-1:0] ca_idx;
  assign in_s = int'(px) >= 0 && int'(py) >= 0 && int'(pz) >= 0 &&
                int'(px) < E && int'(py) < E && int'(pz) < E;
  assign in_a = int'(px) >= -1 && int'(py) >= -1 && int'(pz) >= -1 &&
                int'(px) <= E && int'(py) <= E && int'(pz) <= E;
  assign cs_idx = SW'(int'(ts) * E + int'(px));
  assign ca_idx = AW'(int'(ta) * P + int'(px) + 1);

  // neighbor address select: +x, -x, +y, -y, +z, -z
  logic [2:0]    nsel;
  logic [SW-1:0] n_sa;
  logic [AW-1:0] n_aa;
  logic          n_ok;
  assign nsel = (state == S_V_CHK) ? 3'd0 : 3'(nb + 3'd1);
  always_comb begin
    case (nsel)
      3'd0: begin
        n_sa = SW'(sidx + SW'(1)); n_aa = AW'(aidx + AW'(1)); n_ok = vx != CW'(E - 1);
      end
      3'd1: begin
        n_sa = SW'(sidx - SW'(1)); n_aa = AW'(aidx - AW'(1)); n_ok = vx != '0;
      end
      3'd2: begin
        n_sa = SW'(sidx + SW'(E)); n_aa = AW'(aidx + AW'(P)); n_ok = vy != CW'(E - 1);
      end
      3'd3: begin
        n_sa = SW'(sidx - SW'(E)); n_aa = AW'(aidx - AW'(P)); n_ok = vy != '0;
      end
      3'd4: begin
        n_sa = SW'(sidx + SW'(E2)); n_aa = AW'(aidx + AW'(P2)); n_ok = vz != CW'(E - 1);
      end
      default: begin
        n_sa = SW'(sidx - SW'(E2)); n_aa = AW'(aidx - AW'(P2)); n_ok = vz != '0;
      end
    endcase
  end

  logic       occ, mark, last_vox;
  logic [2:0] cnt_next;
  assign occ      = (nb_ok & s_rd) | a_rd;
  assign cnt_next = cnt + 3'(occ);
  assign mark     = cur_solid && cnt < 3'd6 && cnt < thr;
  assign last_vox = sidx == SW'(SC - 1);

  always_comb begin
    s_we = 1'b0; s_wa = cs_idx; s_wd = bit_r; s_ra = cs_idx;
    a_we = 1'b0; a_wa = ca_idx; a_wd = bit_r; a_ra = n_aa;
    m_we = 1'b0; m_wa = sidx;   m_wd = mark;  m_ra = sidx;
    unique case (state) inside
      S_CLR: begin
        s_we = int'(clr) < SC; s_wa = SW'(clr); s_wd = 1'b0;
        a_we = 1'b1; a_wa = clr; a_wd = 1'b0;
      end
      S_IDX2: begin
        s_we = cmd_r == CMD_LOAD_SOLID && in_s;
        a_we = cmd_r == CMD_LOAD_ANCHOR && in_a;
      end
      S_V_RD: s_ra = sidx;
      S_V_CHK, S_NB: s_ra = n_sa;
      S_DEC: m_we = 1'b1;
      S_SW_WR: begin
        s_we = m_rd; s_wa = sidx; s_wd = 1'b0;
      end
      default: ;
    endcase
  end

  logic [MW:0] rem_sum;
  assign rem_sum = (MW + 1)'(removed) + (MW + 1)'(marked);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr <= '0;
      last_removed <= '0; last_passes <= '0;
      thr <= '0; maxp <= 8'd1;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_THRESHOLD) thr <= cfg_data[2:0];
        else maxp <= cfg_data;
      end
      unique case (state)
        S_CLR: begin
          clr <= AW'(clr + AW'(1));
          if (clr == AW'(AC - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= command; px <= pos_x; py <= pos_y; pz <= pos_z;
            bit_r <= bit_value; state <= S_IDX1;
          end
        end
        S_IDX1: begin
          ts <= SW'(int'(pz) * E + int'(py));
          ta <= AW'((int'(pz) + 1) * P + int'(py) + 1);
          if (cmd_r == CMD_RUN) begin
            removed <= '0; passes <= '0; state <= S_PASS;
          end else begin
            state <= S_IDX2;
          end
        end
        S_IDX2: begin
          rd_ok <= cmd_r == CMD_READ && in_s;
          state <= S_RESP;
        end
        S_RESP: state <= S_IDLE;
        S_PASS: begin
          rd_ok <= 1'b0;
          sidx <= '0; aidx <= AW'(1 + P + P2);
          vx <= '0; vy <= '0; vz <= '0; marked <= '0;
          state <= (passes == maxp) ? S_FINISH : S_V_RD;
        end
        S_V_RD: state <= S_V_CHK;
        S_V_CHK: begin
          cur_solid <= s_rd; cnt <= '0; nb <= '0; nb_ok <= n_ok;
          state <= s_rd ? S_NB : S_DEC;
        end
        S_NB: begin
          cnt <= cnt_next; nb_ok <= n_ok; nb <= 3'(nb + 3'd1);
          if (nb == 3'd5) state <= S_DEC;
        end
        S_DEC: begin
          if (mark) marked <= MW'(marked + MW'(1));
          if (last_vox) begin
            sidx <= '0;
            state <= (marked == '0 && !mark) ? S_FINISH : S_SW_RD;
          end else begin
            sidx <= SW'(sidx + SW'(1));
            state <= S_V_RD;
            if (vx == CW'(E - 1)) begin
              vx <= '0;
              if (vy == CW'(E - 1)) begin
                vy <= '0; vz <= CW'(vz + CW'(1));
                aidx <= AW'(aidx + AW'(3 + 2 * P));
              end else begin
                vy <= CW'(vy + CW'(1));
                aidx <= AW'(aidx + AW'(3));
              end
            end else begin
              vx <= CW'(vx + CW'(1));
              aidx <= AW'(aidx + AW'(1));
            end
          end
        end
        S_SW_RD: state <= S_SW_WR;
        S_SW_WR: begin
          if (last_vox) begin
            removed <= (rem_sum > (MW + 1)'(16'hFFFF)) ? 16'hFFFF : 16'(rem_sum);
            passes <= 8'(passes + 8'd1);
            state <= S_PASS;
          end else begin
            sidx <= SW'(sidx + SW'(1));
            state <= S_SW_RD;
          end
        end
        S_FINISH: begin
          last_removed <= removed; last_passes <= passes;
          state <= S_RESP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy          = state != S_IDLE;
  assign cfg_ready     = 1'b1;
  assign done          = state == S_RESP;
  assign read_bit      = rd_ok & s_rd;
  assign removed_count = last_removed;
  assign passes_done   = last_passes;
endmodule
